// ----- src/npc_pkg.sv -----
package npc_pkg;

  localparam int VALUE_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CAT_W     = 2;
  localparam int BIDX_W    = 4;
  localparam int TOTAL_W   = 16;
  localparam int SUM_W     = 18;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 4'd1;

  localparam logic [CFG_W-1:0] MAX_VALID_RST = 16'd100;
  localparam logic [CFG_W-1:0] BIN_WIDTH_RST = 16'd10;

  // Result categories.
  localparam logic [CAT_W-1:0] CAT_VALID   = 2'd0;
  localparam logic [CAT_W-1:0] CAT_INVALID = 2'd1;
  localparam logic [CAT_W-1:0] CAT_ZERO    = 2'd2;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic bin_start;
    logic bin_rd;
    logic bin_wr;
    logic trial_start;
    logic trial_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_valid;
    logic bw_nonzero;
    logic bin_hit;
    logic div_done;
    logic d_last;
    logic half_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ----- src/npc_in_if.sv -----
interface npc_in_if import npc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ----- src/npc_out_if.sv -----
interface npc_out_if import npc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CAT_W-1:0]   category;
  logic               is_perfect;
  logic               is_prime;
  logic               is_square;
  logic [BIDX_W-1:0]  bin_index;
  logic [TOTAL_W-1:0] bin_total;
  logic [TOTAL_W-1:0] valid_total;
  logic [TOTAL_W-1:0] invalid_total;
  logic [TOTAL_W-1:0] zero_total;

  modport source (output valid, output category, output is_perfect, output is_prime,
                  output is_square, output bin_index, output bin_total,
                  output valid_total, output invalid_total, output zero_total,
                  input ready);
  modport sink (input valid, input category, input is_perfect, input is_prime,
                input is_square, input bin_index, input bin_total,
                input valid_total, input invalid_total, input zero_total,
                output ready);
endinterface

// ----- src/npc_cfg_if.sv -----
interface npc_cfg_if import npc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/npc_ram.sv -----
module npc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/npc_div.sv -----
module npc_div import npc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [VALUE_W-1:0] divisor,
  output logic               done,
  output logic [VALUE_W-1:0] quotient,
  output logic [VALUE_W-1:0] remainder
);

  localparam int STEP_W = $clog2(VALUE_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [VALUE_W-1:0] quo_r, quo_nxt;
  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic [VALUE_W-1:0] dvs_r, dvs_nxt;
  logic [VALUE_W:0]   trial;
  logic               ge;

  // One restoring step per cycle: shift in the next dividend bit and subtract if it fits.
  assign trial = {rem_r, quo_r[VALUE_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? VALUE_W'(trial - {1'b0, dvs_r}) : trial[VALUE_W-1:0];
      quo_nxt  = {quo_r[VALUE_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(VALUE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- src/npc_datapath.sv -----
module npc_datapath import npc_pkg::*; #(
  parameter int NUM_BINS    = 10,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  input  logic [VALUE_W-1:0]   in_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [CAT_W-1:0]     out_category,
  output logic                 out_is_perfect,
  output logic                 out_is_prime,
  output logic                 out_is_square,
  output logic [BIDX_W-1:0]    out_bin_index,
  output logic [TOTAL_W-1:0]   out_bin_total,
  output logic [TOTAL_W-1:0]   out_valid_total,
  output logic [TOTAL_W-1:0]   out_invalid_total,
  output logic [TOTAL_W-1:0]   out_zero_total
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int HALF_W = VALUE_W - 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [31:0] NO_BIN = 32'(NUM_BINS);

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

  function automatic logic [TOTAL_W-1:0] to_total(input logic [COUNT_WIDTH-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    return wide[TOTAL_W-1:0];
  endfunction

  logic [CFG_W-1:0]       max_valid_r, bin_width_r;
  logic [VALUE_W-1:0]     value_r;
  logic [HALF_W-1:0]      d_r;
  logic [1:0]             dcnt_r;
  logic [SUM_W-1:0]       sum_r;
  logic                   sq_r;
  logic                   hit_r;
  logic [AW-1:0]          bidx_r;
  logic [COUNT_WIDTH-1:0] btot_r;
  logic [COUNT_WIDTH-1:0] valid_cnt_r, valid_cnt_nxt;
  logic [COUNT_WIDTH-1:0] invalid_cnt_r, invalid_cnt_nxt;
  logic [COUNT_WIDTH-1:0] zero_cnt_r, zero_cnt_nxt;
  logic [NUM_BINS-1:0]    bin_vld_r;
  logic                   out_valid_r;

  logic                   item_valid;
  logic [HALF_W-1:0]      half;
  logic                   div_start;
  logic [VALUE_W-1:0]     div_dividend, div_divisor;
  logic                   div_done;
  logic [VALUE_W-1:0]     div_quo, div_rem;
  logic [COUNT_WIDTH-1:0] ram_rdata, bin_new;
  logic                   rem_zero;

  assign item_valid = !value_r[VALUE_W-1] && (value_r != '0) && (value_r <= max_valid_r);
  assign half       = value_r[VALUE_W-1:1];
  assign rem_zero   = (div_rem == '0);

  // The shared divider serves the bin lookup first, then every trial divisor.
  assign div_start    = cmd.bin_start | cmd.trial_start;
  assign div_dividend = cmd.bin_start ? value_r - 1'b1 : value_r;
  assign div_divisor  = cmd.bin_start ? bin_width_r : {1'b0, d_r};

  npc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  npc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (cmd.bin_wr),
    .waddr (bidx_r),
    .wdata (bin_new),
    .re    (cmd.bin_rd),
    .raddr (div_quo[AW-1:0]),
    .rdata (ram_rdata)
  );

  // A bin never written since reset reads as zero.
  assign bin_new = sat_inc(bin_vld_r[bidx_r] ? ram_rdata : '0);

  always_comb begin
    status.item_valid = item_valid;
    status.bw_nonzero = (bin_width_r != '0);
    status.bin_hit    = (32'(div_quo) < NO_BIN);
    status.div_done   = div_done;
    status.d_last     = (d_r == half);
    status.half_zero  = (half == '0);
    status.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    valid_cnt_nxt   = valid_cnt_r;
    invalid_cnt_nxt = invalid_cnt_r;
    zero_cnt_nxt    = zero_cnt_r;
    if (item_valid) begin
      valid_cnt_nxt = sat_inc(valid_cnt_r);
    end else begin
      invalid_cnt_nxt = sat_inc(invalid_cnt_r);
      if (value_r == '0) begin
        zero_cnt_nxt = sat_inc(zero_cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_valid_r   <= MAX_VALID_RST;
      bin_width_r   <= BIN_WIDTH_RST;
      valid_cnt_r   <= '0;
      invalid_cnt_r <= '0;
      zero_cnt_r    <= '0;
      bin_vld_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_MAX_VALID) begin
        max_valid_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_BIN_WIDTH) begin
        bin_width_r <= cfg_data;
      end
      if (cmd.bin_wr) begin
        bin_vld_r[bidx_r] <= 1'b1;
      end
      if (cmd.out_load) begin
        valid_cnt_r   <= valid_cnt_nxt;
        invalid_cnt_r <= invalid_cnt_nxt;
        zero_cnt_r    <= zero_cnt_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value_r <= in_value;
      d_r     <= HALF_W'(1);
      dcnt_r  <= '0;
      sum_r   <= '0;
      sq_r    <= 1'b0;
      hit_r   <= 1'b0;
    end
    if (cmd.bin_rd) begin
      hit_r  <= 1'b1;
      bidx_r <= div_quo[AW-1:0];
    end
    if (cmd.bin_wr) begin
      btot_r <= bin_new;
    end
    if (cmd.trial_step) begin
      if (rem_zero) begin
        dcnt_r <= (dcnt_r == 2'd2) ? 2'd2 : dcnt_r + 1'b1;
        sum_r  <= sum_r + SUM_W'(d_r);
        if (div_quo == {1'b0, d_r}) begin
          sq_r <= 1'b1;
        end
      end
      d_r <= d_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_category      <= item_valid ? CAT_VALID : (value_r == '0 ? CAT_ZERO : CAT_INVALID);
      out_is_perfect    <= item_valid && (sum_r == SUM_W'(value_r));
      out_is_prime      <= item_valid && (dcnt_r == 2'd1);
      out_is_square     <= item_valid && (sq_r || value_r == VALUE_W'(1));
      out_bin_index     <= hit_r ? BIDX_W'(bidx_r) : NO_BIN[BIDX_W-1:0];
      out_bin_total     <= hit_r ? to_total(btot_r) : '0;
      out_valid_total   <= to_total(valid_cnt_nxt);
      out_invalid_total <= to_total(invalid_cnt_nxt);
      out_zero_total    <= to_total(zero_cnt_nxt);
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/npc_ctrl.sv -----
module npc_ctrl import npc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE        = 7'b0000001,
    ST_CHECK       = 7'b0000010,
    ST_BIN_DIV     = 7'b0000100,
    ST_BIN_WR      = 7'b0001000,
    ST_TRIAL_START = 7'b0010000,
    ST_TRIAL_WAIT  = 7'b0100000,
    ST_DONE        = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status.item_valid) begin
          state_nxt = ST_DONE;
        end else if (status.bw_nonzero) begin
          cmd.bin_start = 1'b1;
          state_nxt     = ST_BIN_DIV;
        end else begin
          state_nxt = ST_TRIAL_START;
        end
      end
      ST_BIN_DIV: begin
        if (status.div_done) begin
          if (status.bin_hit) begin
            cmd.bin_rd = 1'b1;
            state_nxt  = ST_BIN_WR;
          end else begin
            state_nxt = ST_TRIAL_START;
          end
        end
      end
      ST_BIN_WR: begin
        cmd.bin_wr = 1'b1;
        state_nxt  = ST_TRIAL_START;
      end
      ST_TRIAL_START: begin
        if (status.half_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.trial_start = 1'b1;
          state_nxt       = ST_TRIAL_WAIT;
        end
      end
      ST_TRIAL_WAIT: begin
        if (status.div_done) begin
          cmd.trial_step = 1'b1;
          state_nxt      = status.d_last ? ST_DONE : ST_TRIAL_START;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/number_property_classifier_unit.sv -----
// Number property classifier: one signed 16-bit number comes in on in_chan per request,
// and one result leaves on out_chan per request, carrying the category, the prime,
// perfect and square flags, the histogram bin and the running valid, invalid and zero
// totals. Both channels move a request when valid and ready are high at a rising edge.
// The cfg_chan port writes max_valid (index 0) and bin_width (index 1); it is always
// ready and must only be used while the block is idle.
// One item is processed at a time. An invalid number goes from acceptance through the
// CHECK and DONE states to a loaded result. For a valid number n the shared restoring
// divider runs once for the bin lookup when bin_width is nonzero and once for each
// candidate divisor from 1 to n/2, and the divider's passes set how long it takes.
// in_chan.ready is high only while the controller is idle. A finished result sits in
// the output register, so the next request is taken while the receiver stalls; that
// next result waits in the controller until the output register is free.
// Reset (rst_n low, synchronous) restores the register defaults of 100 and 10, clears
// the totals and marks every histogram bin as empty, with no clearing pass needed.
module number_property_classifier_unit import npc_pkg::*; #(
  parameter int NUM_BINS    = 10,
  parameter int COUNT_WIDTH = 16
) (
  input logic    clk,
  input logic    rst_n,
  npc_in_if.sink    in_chan,
  npc_out_if.source out_chan,
  npc_cfg_if.sink   cfg_chan
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Configuration writes are always taken.
  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = cmd.in_ready;

  npc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the counters, the histogram memory, the
  // divider and the output register.
  npc_datapath #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_value          (in_chan.value),
    .cfg_we            (cfg_chan.valid),
    .cfg_index         (cfg_chan.index),
    .cfg_data          (cfg_chan.data),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_category      (out_chan.category),
    .out_is_perfect    (out_chan.is_perfect),
    .out_is_prime      (out_chan.is_prime),
    .out_is_square     (out_chan.is_square),
    .out_bin_index     (out_chan.bin_index),
    .out_bin_total     (out_chan.bin_total),
    .out_valid_total   (out_chan.valid_total),
    .out_invalid_total (out_chan.invalid_total),
    .out_zero_total    (out_chan.zero_total)
  );

endmodule

// ----- dv/number_property_classifier_unit_test.sv -----
`timescale 1ns / 1ps

module number_property_classifier_unit_test;
  import npc_pkg::*;

  localparam int NUM_BINS    = 10;
  localparam int COUNT_WIDTH = 16;
  localparam int COUNT_MAX   = (1 << COUNT_WIDTH) - 1;

  // Upper bound on the run, set well above the slowest legal run (every random
  // number at the largest size the stimulus draws, every result held by the
  // longest stall).
  localparam int CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [CAT_W-1:0]   category;
    logic               is_perfect;
    logic               is_prime;
    logic               is_square;
    logic [BIDX_W-1:0]  bin_index;
    logic [TOTAL_W-1:0] bin_total;
    logic [TOTAL_W-1:0] valid_total;
    logic [TOTAL_W-1:0] invalid_total;
    logic [TOTAL_W-1:0] zero_total;
  } npc_result_t;

  // The tracker mirrors the block's registers, histogram and counters, works
  // out the result of every accepted number and checks results in order.
  class classify_tracker;
    int          limit_reg;
    int          width_reg;
    int          bin_hits[NUM_BINS];
    int          n_valid;
    int          n_invalid;
    int          n_zero;
    npc_result_t pending[$];
    int          mismatches;
    int          checked;
    int          cat_seen[3];

    function new();
      limit_reg = MAX_VALID_RST;
      width_reg = BIN_WIDTH_RST;
      foreach (bin_hits[k]) bin_hits[k] = 0;
      n_valid    = 0;
      n_invalid  = 0;
      n_zero     = 0;
      mismatches = 0;
      checked    = 0;
      foreach (cat_seen[k]) cat_seen[k] = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_MAX_VALID) begin
        limit_reg = data;
      end else if (idx == REG_BIN_WIDTH) begin
        width_reg = data;
      end
    endfunction

    function int bump(int c);
      return (c >= COUNT_MAX) ? COUNT_MAX : c + 1;
    endfunction

    function npc_result_t classify_number(logic signed [VALUE_W-1:0] v);
      npc_result_t r;
      int n;
      int div_sum;
      int div_count;
      int root;
      int b;
      r = '0;
      r.bin_index = BIDX_W'(NUM_BINS);
      n = v;
      if (n >= 1 && n <= limit_reg) begin
        r.category = CAT_VALID;
        div_sum   = 0;
        div_count = 0;
        for (int d = 1; d <= n; d++) begin
          if (n % d == 0) begin
            div_count++;
            if (d < n) div_sum += d;
          end
        end
        r.is_perfect = (div_sum == n);
        r.is_prime   = (div_count == 2);
        root = 1;
        while (root * root < n) root++;
        r.is_square = (root * root == n);
        n_valid = bump(n_valid);
        if (width_reg != 0) begin
          b = (n - 1) / width_reg;
          if (b < NUM_BINS) begin
            bin_hits[b] = bump(bin_hits[b]);
            r.bin_index = BIDX_W'(b);
            r.bin_total = TOTAL_W'(bin_hits[b]);
          end
        end
      end else begin
        n_invalid = bump(n_invalid);
        if (n == 0) begin
          r.category = CAT_ZERO;
          n_zero = bump(n_zero);
        end else begin
          r.category = CAT_INVALID;
        end
      end
      r.valid_total   = TOTAL_W'(n_valid);
      r.invalid_total = TOTAL_W'(n_invalid);
      r.zero_total    = TOTAL_W'(n_zero);
      return r;
    endfunction

    function void note_request(logic signed [VALUE_W-1:0] v);
      pending.push_back(classify_number(v));
    endfunction

    function string describe(npc_result_t r);
      return $sformatf("cat=%0d perf=%0b prime=%0b sq=%0b bin=%0d btot=%0d v=%0d i=%0d z=%0d",
                       r.category, r.is_perfect, r.is_prime, r.is_square, r.bin_index,
                       r.bin_total, r.valid_total, r.invalid_total, r.zero_total);
    endfunction

    function void check_result(npc_result_t got);
      npc_result_t want;
      checked++;
      if (got.category <= CAT_ZERO) cat_seen[got.category]++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result %0d arrived with nothing outstanding: %s", checked, describe(got));
        end
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on result %0d", checked);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  npc_in_if  in_chan ();
  npc_out_if out_chan ();
  npc_cfg_if cfg_chan ();

  number_property_classifier_unit #(
    .NUM_BINS(NUM_BINS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  classify_tracker tracker;

  // Idling switch shared by the sender and the receiver; the main sequence
  // flips it between stretches so that some runs of requests go back to back.
  bit idling_on;
  int stall_left;
  int settings_used;
  int cycles;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: ready drops at random while idling is enabled.
  // All inputs change at the falling edge, away from the sampling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(7, 0) == 0) begin
      stall_left = $urandom_range(18, 0);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Result monitor. Outputs are sampled at the rising edge, before the block's
  // own registers update in that time step.
  always @(posedge clk) begin : result_monitor
    npc_result_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.category      = out_chan.category;
      got.is_perfect    = out_chan.is_perfect;
      got.is_prime      = out_chan.is_prime;
      got.is_square     = out_chan.is_square;
      got.bin_index     = out_chan.bin_index;
      got.bin_total     = out_chan.bin_total;
      got.valid_total   = out_chan.valid_total;
      got.invalid_total = out_chan.invalid_total;
      got.zero_total    = out_chan.zero_total;
      tracker.check_result(got);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, tracker.pending.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Presents one number and holds it until the block takes it. Valid is left
  // high on return so that a following request can go out without a gap.
  task automatic send_value(logic signed [VALUE_W-1:0] v);
    int gap;
    if (idling_on && $urandom_range(3, 0) == 0) begin
      gap = $urandom_range(19, 1);
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.value <= v;
    do @(posedge clk); while (!in_chan.ready);
    tracker.note_request(v);
  endtask

  // Lowers valid and waits until every outstanding result has come back, plus
  // a few cycles, so that a register write lands on an idle block.
  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (tracker.pending.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    tracker.set_register(idx, data);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic apply_setting(int limit, int width);
    drain_results();
    write_register(REG_MAX_VALID, CFG_W'(limit));
    write_register(REG_BIN_WIDTH, CFG_W'(width));
    settings_used++;
  endtask

  // Random number for a given limit. Most numbers are small and in range, since
  // trial division makes large valid numbers slow; the rest are zeros,
  // negatives, numbers just past the limit and numbers well beyond it.
  function automatic logic signed [VALUE_W-1:0] pick_value(int limit);
    int sel;
    int top;
    sel = $urandom_range(99, 0);
    if (sel < 8) return '0;
    if (sel < 20) return {1'b1, 15'($urandom)};
    if (limit < 1) return VALUE_W'($urandom_range(32767, 1));
    if (sel < 28) begin
      if (limit < 32767) return VALUE_W'($urandom_range(32767, limit + 1));
      return {1'b1, 15'($urandom)};
    end
    if (sel < 31) return VALUE_W'((limit <= 1023) ? limit : $urandom_range(1023, 1));
    if (sel < 33 && limit < 32767) return VALUE_W'(limit + 1);
    top = (limit < 1023) ? limit : 1023;
    if (sel < 38) return VALUE_W'($urandom_range(top, 1));
    top = (limit < 160) ? limit : 160;
    return VALUE_W'($urandom_range(top, 1));
  endfunction

  initial begin
    int opening[16] = '{1, 2, 4, 6, 10, 11, 28, 49, 97, 100, 101, 0, -1, -32768, 32767, 81};
    int limit;
    int width;
    int failures;

    tracker        = new();
    idling_on      = 1'b0;
    stall_left     = 0;
    settings_used  = 1;
    cycles         = 0;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.value  = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data  = '0;
    out_chan.ready = 1'b0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset settings (limit 100, bins of ten): the
    // first primes, perfect numbers and squares, both edges of a bin, the
    // top of the valid range and one past it, zero, and the field extremes.
    idling_on = 1'b1;
    foreach (opening[k]) send_value(VALUE_W'(opening[k]));

    // Widest valid range with single-unit bins: the largest positive number is
    // valid here and lands past the histogram, as do the perfect 496 and 11.
    apply_setting(65535, 1);
    send_value(16'sd32767);
    send_value(16'sd10);
    send_value(16'sd11);
    send_value(16'sd496);

    // A zero limit makes every number invalid.
    apply_setting(0, 0);
    send_value(16'sd1);
    send_value(16'sd0);

    // A zero bin width leaves valid numbers without a bin.
    apply_setting(200, 0);
    send_value(16'sd7);
    send_value(16'sd196);

    // Random phases, each under its own setting. The histogram and counters
    // carry over between phases, as they do in the block.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          limit = 1;
          width = 1;
        end
        1: begin
          limit = 65535;
          width = 65535;
        end
        2: begin
          limit = $urandom_range(300, 20);
          width = $urandom_range(40, 1);
        end
        3: begin
          limit = $urandom_range(1000, 100);
          width = 0;
        end
        4: begin
          limit = $urandom_range(120, 1);
          width = $urandom_range(12, 1);
        end
        default: begin
          limit = 32767;
          width = $urandom_range(3000, 1);
        end
      endcase
      apply_setting(limit, width);
      for (int k = 0; k < 70; k++) begin
        if (k % 25 == 0) idling_on = ($urandom_range(3, 0) != 0);
        send_value(pick_value(limit));
      end
    end

    // Closing part without idling: a back-to-back run of random numbers under
    // the reset settings, then a zero, a valid and a negative number.
    idling_on = 1'b0;
    apply_setting(100, 10);
    for (int k = 0; k < 12; k++) send_value(pick_value(100));
    send_value('0);
    send_value(16'sd5);
    send_value(-16'sd3);

    drain_results();
    repeat (40) @(posedge clk);

    failures = tracker.mismatches + tracker.pending.size();
    $display("Checked %0d results under %0d register settings in %0d cycles.",
             tracker.checked, settings_used, cycles);
    $display("Seen %0d in range, %0d out of range and %0d zeros, directed and random.",
             tracker.cat_seen[CAT_VALID], tracker.cat_seen[CAT_INVALID],
             tracker.cat_seen[CAT_ZERO]);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived.",
               tracker.mismatches, tracker.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
